>>> rtl/prp_pkg.sv
package prp_pkg;

  localparam int unsigned ANGLE_W     = 10;
  localparam int unsigned ANGLE_STEPS = 1024;
  localparam int unsigned QUARTER     = ANGLE_STEPS / 4;
  localparam int unsigned QIDX_W      = $clog2(QUARTER) + 1;
  localparam int unsigned TRIG_W      = 16;
  localparam int unsigned COEF_W      = 17;
  localparam int unsigned POINT_W     = 18;
  localparam int unsigned PROD_W      = POINT_W + COEF_W;
  localparam int unsigned ROT_W       = 36;
  localparam int unsigned NUM_W       = 46;
  localparam int unsigned DEN_W       = 36;
  localparam int unsigned QUO_W       = 21;
  localparam int unsigned CMP_W       = DEN_W + QUO_W;
  localparam int unsigned LANES       = 3;
  localparam int unsigned CFG_W       = 21;
  localparam int unsigned CAM_W       = 21;
  localparam int unsigned CENTER_W    = 12;
  localparam int unsigned FOCAL_W     = 10;
  localparam int unsigned SCREEN_W    = 16;
  localparam int unsigned SPRITE_W    = 21;
  localparam int unsigned SPRITE_K    = 16384000;

  localparam real QUARTER_STEP = 3.14159265358979323846 / real'(2 * QUARTER);

  localparam logic signed [CAM_W-1:0] RST_CAMERA   = 21'sd20000;
  localparam logic [CENTER_W-1:0]     RST_CENTER_X = 12'd160;
  localparam logic [CENTER_W-1:0]     RST_CENTER_Y = 12'd100;
  localparam logic [FOCAL_W-1:0]      RST_FOCAL    = 10'd256;

  typedef enum logic [2:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_CAMERA   = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_FOCAL    = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef trig_t quarter_t [QUARTER+1];

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [DEN_W-1:0]            den;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            ovf;
    logic                        zero;
    logic                        last;
  } div_word_t;

  function automatic quarter_t gen_quarter();
    quarter_t t;
    real      ph;
    for (int i = 0; i <= QUARTER; i++) begin
      ph   = QUARTER_STEP * real'(i);
      t[i] = trig_t'($rtoi(16384.0 * $sin(ph) + 0.5));
    end
    return t;
  endfunction

  localparam quarter_t SIN_QUARTER = gen_quarter();

  function automatic trig_t sin_q14(input logic [ANGLE_W-1:0] a);
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] rf;
    trig_t             s;
    r  = QIDX_W'(a[ANGLE_W-3:0]);
    rf = QIDX_W'(QUARTER) - r;
    case (quad_e'(a[ANGLE_W-1 -: 2]))
      QUAD_0:  s = SIN_QUARTER[r];
      QUAD_1:  s = SIN_QUARTER[rf];
      QUAD_2:  s = -SIN_QUARTER[r];
      default: s = -SIN_QUARTER[rf];
    endcase
    return s;
  endfunction

  function automatic trig_t cos_q14(input logic [ANGLE_W-1:0] a);
    return sin_q14(a + ANGLE_W'(QUARTER));
  endfunction

endpackage

>>> rtl/prp_coef.sv
module prp_coef (
  input  logic                        clk_i,
  input  logic [prp_pkg::ANGLE_W-1:0] angle_x_i,
  input  logic [prp_pkg::ANGLE_W-1:0] angle_y_i,
  input  logic [prp_pkg::ANGLE_W-1:0] angle_z_i,
  output prp_pkg::coef_t              mat_o [9]
);
  import prp_pkg::*;

  function automatic coef_t qm(input coef_t a, input coef_t b);
    logic signed [2*COEF_W-1:0] p;
    p = a * b;
    return p[COEF_W+13:14];
  endfunction

  coef_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  coef_t sxsy_q, cxsy_q, sz2_q, cz2_q;
  coef_t cxsz_q, cxcz_q, sxsz_q, sxcz_q;
  coef_t m0_q, m1_q, m2_q, m5_q, m8_q;
  coef_t mat_q [9];

  always_ff @(posedge clk_i) begin
    sx_q <= coef_t'(sin_q14(angle_x_i));
    cx_q <= coef_t'(cos_q14(angle_x_i));
    sy_q <= coef_t'(sin_q14(angle_y_i));
    cy_q <= coef_t'(cos_q14(angle_y_i));
    sz_q <= coef_t'(sin_q14(angle_z_i));
    cz_q <= coef_t'(cos_q14(angle_z_i));
  end

  always_ff @(posedge clk_i) begin
    sxsy_q <= qm(sx_q, sy_q);
    cxsy_q <= qm(cx_q, sy_q);
    sz2_q  <= sz_q;
    cz2_q  <= cz_q;
    cxsz_q <= qm(cx_q, sz_q);
    cxcz_q <= qm(cx_q, cz_q);
    sxsz_q <= qm(sx_q, sz_q);
    sxcz_q <= qm(sx_q, cz_q);
    m0_q   <= qm(cy_q, cz_q);
    m1_q   <= qm(cy_q, sz_q);
    m2_q   <= -sy_q;
    m5_q   <= qm(sx_q, cy_q);
    m8_q   <= qm(cx_q, cy_q);
  end

  always_ff @(posedge clk_i) begin
    mat_q[0] <= m0_q;
    mat_q[1] <= m1_q;
    mat_q[2] <= m2_q;
    mat_q[3] <= qm(sxsy_q, cz2_q) - cxsz_q;
    mat_q[4] <= qm(sxsy_q, sz2_q) + cxcz_q;
    mat_q[5] <= m5_q;
    mat_q[6] <= qm(cxsy_q, cz2_q) + sxsz_q;
    mat_q[7] <= qm(cxsy_q, sz2_q) - sxcz_q;
    mat_q[8] <= m8_q;
  end

  assign mat_o = mat_q;

endmodule

>>> rtl/prp_div_cell.sv
module prp_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  prp_pkg::div_word_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output prp_pkg::div_word_t data_o
);
  import prp_pkg::*;

  logic               valid_q;
  div_word_t          word_q;
  div_word_t          word_d;
  logic [CMP_W-1:0]   shifted;
  logic [CMP_W:0]     trial [LANES];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    word_d  = data_i;
    shifted = CMP_W'(data_i.den) << BIT;
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {1'b0, CMP_W'(data_i.rem[l])} - {1'b0, shifted};
      if (!trial[l][CMP_W]) begin
        word_d.rem[l]      = trial[l][NUM_W-1:0];
        word_d.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = word_q;

`ifndef SYNTHESIS
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !word_q.zero && word_q.ovf == '0) |->
      ((CMP_W'(word_q.rem[0]) < (CMP_W'(word_q.den) << BIT)) &&
       (CMP_W'(word_q.rem[1]) < (CMP_W'(word_q.den) << BIT)) &&
       (CMP_W'(word_q.rem[2]) < (CMP_W'(word_q.den) << BIT))))
    else $error("remainder not reduced below shifted divisor");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(word_q)))
    else $error("word changed while stalled");
`endif

endmodule

>>> rtl/point_rotate_project_unit.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata: point_x, point_y, point_z; tlast: last_point
// m_axis   | out       | tdata: screen_x, screen_y, sprite_size; tuser: point_valid;
//          |           | tlast: last_out
// cfg      | in        | cfg_addr_i: register index, cfg_data_i: value
// One point per cycle unless s_axis is blocked or m_axis stalls; five rotate/project
// stages, 21 divider stages (one quotient bit each), one output register.
// Each stage advances into a free slot, so bubbles collapse under output stalls.
// An angle write blocks s_axis while the matrix rebuilds.
// Reset holds s_axis off while the identity matrix is formed.
module point_rotate_project_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [55:0]                 s_axis_tdata,  // point_x, point_y, point_z
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,  // screen_x, screen_y, sprite_size
  output logic                        m_axis_tuser,  // point_valid
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  prp_pkg::reg_idx_e           cfg_addr_i,
  input  logic [prp_pkg::CFG_W-1:0]   cfg_data_i
);
  import prp_pkg::*;

  logic [ANGLE_W-1:0]         angle_x_q, angle_y_q, angle_z_q;
  logic signed [CAM_W-1:0]    camera_q;
  logic [CENTER_W-1:0]        center_x_q, center_y_q;
  logic [FOCAL_W-1:0]         focal_q;
  logic [1:0]                 busy_q;
  logic                       cfg_wr, angle_wr;
  coef_t                      mat [9];

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign angle_wr    = cfg_wr && (cfg_addr_i inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q  <= '0;
      angle_y_q  <= '0;
      angle_z_q  <= '0;
      camera_q   <= RST_CAMERA;
      center_x_q <= RST_CENTER_X;
      center_y_q <= RST_CENTER_Y;
      focal_q    <= RST_FOCAL;
    end else if (cfg_wr) begin
      case (cfg_addr_i)
        REG_ANGLE_X:  angle_x_q  <= cfg_data_i[ANGLE_W-1:0];
        REG_ANGLE_Y:  angle_y_q  <= cfg_data_i[ANGLE_W-1:0];
        REG_ANGLE_Z:  angle_z_q  <= cfg_data_i[ANGLE_W-1:0];
        REG_CAMERA:   camera_q   <= $signed(cfg_data_i[CAM_W-1:0]);
        REG_CENTER_X: center_x_q <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[CENTER_W-1:0];
        REG_FOCAL:    focal_q    <= cfg_data_i[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 2'd3;
    end else if (angle_wr) begin
      busy_q <= 2'd3;
    end else if (busy_q != 2'd0) begin
      busy_q <= busy_q - 2'd1;
    end
  end

  prp_coef u_coef (
    .clk_i     (clk_i),
    .angle_x_i (angle_x_q),
    .angle_y_i (angle_y_q),
    .angle_z_i (angle_z_q),
    .mat_o     (mat)
  );

  logic                        v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic                        rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic                        in_vld;
  logic signed [POINT_W-1:0]   px_q, py_q, pz_q;
  logic                        l1_q, l2_q, l3_q, l4_q;
  logic signed [PROD_W-1:0]    prod_q [9];
  logic signed [ROT_W-1:0]     rx_q, ry_q, rz_q;
  logic signed [NUM_W-1:0]     nx_q, ny_q;
  logic [NUM_W-1:0]            ns_q;
  logic signed [DEN_W-1:0]     depth_q;
  div_word_t                   w5_d, w5_q;
  logic [NUM_W-1:0]            nmag [LANES];
  logic [DEN_W-1:0]            dmag;
  logic [LANES-1:0]            nneg;

  logic [QUO_W:0]              c_vld, c_rdy;
  div_word_t                   c_word [QUO_W+1];

  assign in_vld        = s_axis_tvalid && (busy_q == 2'd0);
  assign s_axis_tready = rdy1 && (busy_q == 2'd0);
  assign rdy_out       = !vo_q || m_axis_tready;
  assign rdy5          = !v5_q || c_rdy[0];
  assign rdy4          = !v4_q || rdy5;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_vld;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_vld) begin
      px_q <= $signed(s_axis_tdata[POINT_W-1:0]);
      py_q <= $signed(s_axis_tdata[2*POINT_W-1:POINT_W]);
      pz_q <= $signed(s_axis_tdata[3*POINT_W-1:2*POINT_W]);
      l1_q <= s_axis_tlast;
    end
    if (rdy2 && v1_q) begin
      prod_q[0] <= px_q * mat[0];
      prod_q[1] <= py_q * mat[1];
      prod_q[2] <= pz_q * mat[2];
      prod_q[3] <= px_q * mat[3];
      prod_q[4] <= py_q * mat[4];
      prod_q[5] <= pz_q * mat[5];
      prod_q[6] <= px_q * mat[6];
      prod_q[7] <= py_q * mat[7];
      prod_q[8] <= pz_q * mat[8];
      l2_q      <= l1_q;
    end
    if (rdy3 && v2_q) begin
      rx_q <= ROT_W'(prod_q[0]) + ROT_W'(prod_q[1]) + ROT_W'(prod_q[2]);
      ry_q <= ROT_W'(prod_q[3]) + ROT_W'(prod_q[4]) + ROT_W'(prod_q[5]);
      rz_q <= ROT_W'(prod_q[6]) + ROT_W'(prod_q[7]) + ROT_W'(prod_q[8]);
      l3_q <= l2_q;
    end
    if (rdy4 && v3_q) begin
      nx_q    <= $signed(NUM_W'(focal_q)) * NUM_W'(rx_q);
      ny_q    <= $signed(NUM_W'(focal_q)) * NUM_W'(ry_q);
      ns_q    <= NUM_W'(focal_q) * NUM_W'(SPRITE_K);
      depth_q <= $signed({camera_q[CAM_W-1], camera_q, 14'b0}) - rz_q;
      l4_q    <= l3_q;
    end
    if (rdy5 && v4_q) begin
      w5_q <= w5_d;
    end
  end

  always_comb begin
    nneg    = {1'b0, ny_q[NUM_W-1], nx_q[NUM_W-1]};
    nmag[0] = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
    nmag[1] = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
    nmag[2] = ns_q;
    dmag    = depth_q[DEN_W-1] ? DEN_W'(-depth_q) : DEN_W'(depth_q);
    w5_d      = '0;
    w5_d.den  = dmag;
    w5_d.zero = (depth_q == '0);
    w5_d.last = l4_q;
    for (int l = 0; l < LANES; l++) begin
      w5_d.rem[l] = nmag[l];
      w5_d.neg[l] = nneg[l] ^ depth_q[DEN_W-1];
      w5_d.ovf[l] = CMP_W'(nmag[l]) >= (CMP_W'(dmag) << QUO_W);
    end
  end

  assign c_vld[0]     = v5_q;
  assign c_word[0]    = w5_q;
  assign c_rdy[QUO_W] = rdy_out;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    prp_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_vld[k]),
      .ready_o (c_rdy[k]),
      .data_i  (c_word[k]),
      .valid_o (c_vld[k+1]),
      .ready_i (c_rdy[k+1]),
      .data_o  (c_word[k+1])
    );
  end

  function automatic logic signed [SCREEN_W-1:0] sat_screen(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7fff;
    if (v < -24'sd32768) return 16'sh8000;
    return v[SCREEN_W-1:0];
  endfunction

  function automatic logic signed [SPRITE_W-1:0] sat_sprite(input logic signed [22:0] v);
    if (v > 23'sd1048575) return 21'sh0fffff;
    if (v < -23'sd1048576) return 21'sh100000;
    return v[SPRITE_W-1:0];
  endfunction

  div_word_t                   wf;
  logic signed [22:0]          qv [LANES];
  logic signed [SCREEN_W-1:0]  sx_d, sy_d;
  logic signed [SPRITE_W-1:0]  ss_d;
  logic signed [SCREEN_W-1:0]  sx_q, sy_q;
  logic signed [SPRITE_W-1:0]  ss_q;
  logic                        pv_q, lo_q;

  always_comb begin
    wf = c_word[QUO_W];
    for (int l = 0; l < LANES; l++) begin
      qv[l] = wf.neg[l] ? -$signed({2'b0, wf.quo[l]}) : $signed({2'b0, wf.quo[l]});
    end
    if (wf.ovf[0]) sx_d = wf.neg[0] ? 16'sh8000 : 16'sh7fff;
    else           sx_d = sat_screen(24'(qv[0]) + $signed({12'b0, center_x_q}));
    if (wf.ovf[1]) sy_d = wf.neg[1] ? 16'sh8000 : 16'sh7fff;
    else           sy_d = sat_screen(24'(qv[1]) + $signed({12'b0, center_y_q}));
    if (wf.ovf[2]) ss_d = wf.neg[2] ? 21'sh100000 : 21'sh0fffff;
    else           ss_d = sat_sprite(qv[2]);
    if (wf.zero) begin
      sx_d = '0;
      sy_d = '0;
      ss_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_out) begin
      vo_q <= c_vld[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && c_vld[QUO_W]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      ss_q <= ss_d;
      pv_q <= !wf.zero;
      lo_q <= wf.last;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {3'b0, ss_q, sy_q, sx_q};
  assign m_axis_tuser  = pv_q;
  assign m_axis_tlast  = lo_q;

`ifndef SYNTHESIS
  a_angle_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_wr |=> !s_axis_tready)
    else $error("point accepted while matrix rebuilds");

  a_zero_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zero-depth word carries nonzero data");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("output word changed while stalled");
`endif

endmodule
